// ===== design/wavhp_pkg.sv =====
package wavhp_pkg;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_BITS     = 3'd2,
    ST_CHANNELS = 3'd3,
    ST_DATA     = 3'd4
  } parse_status_t;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    parse_status_t parse_status;
    logic [15:0]   channel_count;
    logic [31:0]   rate_hz;
    logic [15:0]   sample_bits;
    logic [31:0]   payload_offset;
    logic [31:0]   payload_size;
    logic [30:0]   sample_total;
  } result_t;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam int unsigned MIN_LEN      = 44;
  localparam int unsigned WANT_BITS    = 16;
  localparam int unsigned HEADER_START = 12;
  localparam int unsigned HEADER_BYTES = 8;

  localparam logic [5:0] POS_RIFF_END = 6'd4;
  localparam logic [5:0] POS_WAVE     = 6'd8;
  localparam logic [5:0] POS_WAVE_END = 6'd12;
  localparam logic [5:0] POS_CH_LO    = 6'd22;
  localparam logic [5:0] POS_CH_HI    = 6'd23;
  localparam logic [5:0] POS_RATE     = 6'd24;
  localparam logic [5:0] POS_RATE_END = 6'd28;
  localparam logic [5:0] POS_BITS_LO  = 6'd34;
  localparam logic [5:0] POS_BITS_HI  = 6'd35;

  localparam logic [2:0] HDR_LAST_IDX = 3'd7;

  function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] k);
    tag_byte = tag[{k, 3'b000} +: 8];
  endfunction

endpackage

// ===== design/wavhp_in_reg.sv =====
module wavhp_in_reg
  import wavhp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     out_free,
  output logic     fire,
  output in_item_t item
);

  logic     valid_r;
  in_item_t item_r;

  assign fire     = valid_r && (!item_r.final_byte || out_free);
  assign in_ready = !valid_r || fire;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

// ===== design/wavhp_decode.sv =====
module wavhp_decode
  import wavhp_pkg::*;
#(
  parameter int LENGTH_BITS = 32
)
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fire,
  input  in_item_t item,
  output result_t  result
);

  localparam int LB = LENGTH_BITS;
  localparam int EW = ((LB > 32) ? LB : 32) + 2;
  localparam int PW = (LB > 32) ? LB : 32;
  localparam logic [LB-1:0] POS_MAX = '1;

  logic [LB-1:0] pos_r, pos_nxt;
  logic          tags_ok_r, tags_ok_nxt;
  logic [15:0]   ch_r, ch_nxt;
  logic [31:0]   rate_r, rate_nxt;
  logic [15:0]   bits_r, bits_nxt;
  logic [LB-1:0] nhp_r, nhp_nxt;
  logic [LB:0]   off8_r, off8_nxt;
  logic [63:0]   shift_r, shift_nxt;
  logic          hdr_act_r, hdr_act_nxt;
  logic [2:0]    hdr_idx_r, hdr_idx_nxt;
  logic          found_r, found_nxt;
  logic [LB-1:0] foff_r, foff_nxt;
  logic [31:0]   fsize_r, fsize_nxt;
  logic [EW-1:0] fend_r, fend_nxt;

  logic          live;
  logic          near;
  logic [5:0]    pidx;
  logic [7:0]    b;
  logic [LB-1:0] pos1;
  logic [LB-1:0] len;
  logic          hdr_hit;
  logic [2:0]    idx;
  logic [63:0]   shift_new;
  logic [31:0]   csize;
  logic [EW-1:0] skip_sum;
  logic          data_bad;
  logic [PW-1:0] foff_wide;

  assign b    = item.file_byte;
  assign live = (pos_r != POS_MAX);
  assign near = ((pos_r >> 6) == '0);
  assign pidx = pos_r[5:0];
  assign pos1 = pos_r + LB'(1);
  assign len  = live ? pos1 : POS_MAX;

  assign hdr_hit   = live && !found_r && (hdr_act_r || (pos_r == nhp_r));
  assign idx       = hdr_act_r ? hdr_idx_r : 3'd0;
  assign shift_new = {b, shift_r[63:8]};
  assign csize     = shift_new[63:32];
  assign skip_sum  = EW'(off8_r) + EW'(csize);

  always_comb begin
    tags_ok_nxt = tags_ok_r;
    ch_nxt      = ch_r;
    rate_nxt    = rate_r;
    bits_nxt    = bits_r;
    if (live && near) begin
      if (pidx < POS_RIFF_END) begin
        if (b != tag_byte(TAG_RIFF, pidx[1:0])) tags_ok_nxt = 1'b0;
      end else if (pidx >= POS_WAVE && pidx < POS_WAVE_END) begin
        if (b != tag_byte(TAG_WAVE, pidx[1:0])) tags_ok_nxt = 1'b0;
      end else if (pidx == POS_CH_LO) begin
        ch_nxt[7:0] = b;
      end else if (pidx == POS_CH_HI) begin
        ch_nxt[15:8] = b;
      end else if (pidx >= POS_RATE && pidx < POS_RATE_END) begin
        rate_nxt[{pidx[1:0], 3'b000} +: 8] = b;
      end else if (pidx == POS_BITS_LO) begin
        bits_nxt[7:0] = b;
      end else if (pidx == POS_BITS_HI) begin
        bits_nxt[15:8] = b;
      end
    end
  end

  always_comb begin
    pos_nxt     = live ? pos1 : pos_r;
    nhp_nxt     = nhp_r;
    off8_nxt    = off8_r;
    shift_nxt   = shift_r;
    hdr_act_nxt = hdr_act_r;
    hdr_idx_nxt = hdr_idx_r;
    found_nxt   = found_r;
    foff_nxt    = foff_r;
    fsize_nxt   = fsize_r;
    fend_nxt    = fend_r;
    if (hdr_hit) begin
      shift_nxt = shift_new;
      if (!hdr_act_r) begin
        off8_nxt = {1'b0, nhp_r} + (LB+1)'(HEADER_BYTES);
      end
      if (idx == HDR_LAST_IDX) begin
        hdr_act_nxt = 1'b0;
        hdr_idx_nxt = 3'd0;
        if (shift_new[31:0] == TAG_DATA) begin
          found_nxt = 1'b1;
          foff_nxt  = pos1;
          fsize_nxt = csize;
          fend_nxt  = EW'(pos1) + EW'(csize);
        end else begin
          nhp_nxt = (skip_sum > EW'(POS_MAX)) ? POS_MAX : skip_sum[LB-1:0];
        end
      end else begin
        hdr_act_nxt = 1'b1;
        hdr_idx_nxt = idx + 3'd1;
      end
    end
  end

  // a data chunk found on the final byte is necessarily empty or overrunning
  assign data_bad = !found_r || (fsize_r == '0) || (fend_r > EW'(len));
  assign foff_wide = PW'(foff_nxt);

  always_comb begin
    if (len < LB'(MIN_LEN) || !tags_ok_nxt) begin
      result.parse_status = ST_SHORT;
    end else if (bits_nxt != 16'(WANT_BITS)) begin
      result.parse_status = ST_BITS;
    end else if (ch_nxt != 16'd1 && ch_nxt != 16'd2) begin
      result.parse_status = ST_CHANNELS;
    end else if (data_bad) begin
      result.parse_status = ST_DATA;
    end else begin
      result.parse_status = ST_OK;
    end
    result.channel_count  = ch_nxt;
    result.rate_hz        = rate_nxt;
    result.sample_bits    = bits_nxt;
    result.payload_offset = foff_wide[31:0];
    result.payload_size   = fsize_nxt;
    result.sample_total   = fsize_nxt[31:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (fire && item.final_byte)) begin
      pos_r     <= '0;
      tags_ok_r <= 1'b1;
      ch_r      <= '0;
      rate_r    <= '0;
      bits_r    <= '0;
      nhp_r     <= LB'(HEADER_START);
      off8_r    <= '0;
      shift_r   <= '0;
      hdr_act_r <= 1'b0;
      hdr_idx_r <= '0;
      found_r   <= 1'b0;
      foff_r    <= '0;
      fsize_r   <= '0;
      fend_r    <= '0;
    end else if (fire) begin
      pos_r     <= pos_nxt;
      tags_ok_r <= tags_ok_nxt;
      ch_r      <= ch_nxt;
      rate_r    <= rate_nxt;
      bits_r    <= bits_nxt;
      nhp_r     <= nhp_nxt;
      off8_r    <= off8_nxt;
      shift_r   <= shift_nxt;
      hdr_act_r <= hdr_act_nxt;
      hdr_idx_r <= hdr_idx_nxt;
      found_r   <= found_nxt;
      foff_r    <= foff_nxt;
      fsize_r   <= fsize_nxt;
      fend_r    <= fend_nxt;
    end
  end

endmodule

// ===== design/wavhp_out_reg.sv =====
module wavhp_out_reg
  import wavhp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t result,
  output logic    out_free,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result
);

  logic    valid_r;
  result_t result_r;

  assign out_free   = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_result = result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

endmodule

// ===== design/wav_header_parser_core.sv =====
// WAV header parser. Feed the file one byte per transaction on in_tdata, with in_tlast
// on the last byte; one status transaction comes out per file, after which the block is
// back in its reset state for the next file. It takes one byte per cycle: a byte sits in
// an input register, one pass of compare and add logic updates the parse state, and the
// status lands in an output register, so bytes keep flowing while a status waits; only a
// final byte is held in the input register until the pending status has been taken.
// Status 0 ok, 1 short or bad RIFF/WAVE tags, 2 bits not 16, 3 channels not 1 or 2,
// 4 data chunk missing, empty or overrunning. LENGTH_BITS sets the width of the byte
// position and chunk skip arithmetic; positions saturate at its all-ones value.
module wav_header_parser_core
  import wavhp_pkg::*;
#(
  parameter int LENGTH_BITS = 32
)
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // file_byte
  input  logic         in_tlast,   // final_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  // parse_status[2:0], channel_count[18:3], rate_hz[50:19], sample_bits[66:51],
  // payload_offset[98:67], payload_size[130:99], sample_total[161:131], zero[167:162]
  output logic [167:0] out_tdata
);

  in_item_t in_item;
  in_item_t item;
  logic     fire;
  logic     out_free;
  result_t  result;
  result_t  out_result;

  assign in_item.file_byte  = in_tdata;
  assign in_item.final_byte = in_tlast;

  wavhp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .out_free (out_free),
    .fire     (fire),
    .item     (item)
  );

  wavhp_decode #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item),
    .result (result)
  );

  wavhp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire && item.final_byte),
    .result     (result),
    .out_free   (out_free),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result)
  );

  assign out_tdata = {6'd0, out_result.sample_total, out_result.payload_size,
                      out_result.payload_offset, out_result.sample_bits,
                      out_result.rate_hz, out_result.channel_count,
                      3'(out_result.parse_status)};

endmodule
